### src/csid_pkg.sv
// Shared types, constants and helpers for the console sub input decode block.
// Holds payload structs, configuration register codes, fixed-point constants
// and the sine series used to build the lookup tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csid_pkg;

    localparam int SAMPLE_WIDTH = 24;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_left;
        logic signed [SAMPLE_WIDTH-1:0] sample_right;
    } csid_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_left;
        logic signed [SAMPLE_WIDTH-1:0] out_right;
    } csid_out_t;

    typedef enum logic [2:0] {
        CFG_IIR_AMOUNT_A  = 3'd0,
        CFG_TAP_SPACING   = 3'd1,
        CFG_BIQUAD_ENABLE = 3'd2,
        CFG_COEF_A0       = 3'd3,
        CFG_COEF_B1       = 3'd4,
        CFG_COEF_B2       = 3'd5
    } cfg_index_t;

    // tap spacing codes; any code above TAP_D2 gives the widest spacing
    localparam logic [1:0] TAP_D1 = 2'd0;
    localparam logic [1:0] TAP_D2 = 2'd1;

    localparam logic [31:0] IIR_AMOUNT_A_RST = 32'd1232977;

    localparam logic signed [28:0] THRESH_Q22 =
        29'(((64'd73824539 << 22) + 64'd50000000) / 64'd100000000);
    localparam logic signed [36:0] BEND_Q30 =
        37'(((64'd26175461 << 30) + 64'd50000000) / 64'd100000000);
    localparam logic signed [31:0] HALFPI_Q22 =
        32'(((64'd157079633 << 22) + 64'd50000000) / 64'd100000000);
    localparam longint HALFPI_Q30 =
        longint'(((64'd157079633 << 30) + 64'd50000000) / 64'd100000000);
    localparam logic signed [36:0] TWO_OVER_PI_Q30 =
        37'(((64'd63661977 << 30) + 64'd50000000) / 64'd100000000);
    localparam logic [40:0] EPS_Q32 = 41'(((64'd1 << 32) + 64'd50000) / 64'd100000);
    localparam logic [40:0] RATE2_CAP = 41'(64'd1 << 35);
    localparam logic signed [31:0] ONE_Q22 = 32'(64'd1 << 22);

    localparam logic signed [47:0] SAT40_MAX = 48'sd549755813887;
    localparam logic signed [47:0] SAT40_MIN = -48'sd549755813888;
    localparam logic signed [47:0] SAT26_MAX = 48'sd33554431;
    localparam logic signed [47:0] SAT26_MIN = -48'sd33554432;

    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        if (v > SAT40_MAX) return SAT40_MAX[39:0];
        if (v < SAT40_MIN) return SAT40_MIN[39:0];
        return v[39:0];
    endfunction

    function automatic logic signed [25:0] sat26(input logic signed [47:0] v);
        if (v > SAT26_MAX) return SAT26_MAX[25:0];
        if (v < SAT26_MIN) return SAT26_MIN[25:0];
        return v[25:0];
    endfunction

    // Taylor sine of a Q.30 angle, elaboration only
    function automatic longint sin_series(input longint x);
        logic [63:0] ux;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        ux   = 64'(x);
        x2   = (ux * ux) >> 30;
        term = ux;
        sum  = x;
        for (int k = 1; k <= 10; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                default: term = term / 64'd420;
            endcase
            if ((k & 1) != 0) sum = sum - longint'(term);
            else              sum = sum + longint'(term);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

### src/console_sub_input_decode.sv
// Console sub input decode: stereo highpass, slew soften, biquad, arcsine.
// Top level; one shared multiplier under a sequencer. Depends on csid_pkg.
//
//  channel  ports                            dir  word
//  s_       s_valid s_ready s_data           in   csid_in_t sample pair
//  m_       m_valid m_ready m_data           out  csid_out_t decoded pair
//  cfg_     cfg_valid cfg_ready cfg_index    in   register index, 32-bit data
//           cfg_wdata
//
// An item runs both channels in turn, its time set by the two-pass shared
// multiplier (up to 10 uses per channel) and the registered table reads.
// The bend path adds four of those uses per channel and the biquad path three.
// Reset clears filter state and loads the register defaults; tables are constants.
// s_ready is high only between items; a waiting output word holds the block in
// its final step until taken. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module console_sub_input_decode
    import csid_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire csid_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output csid_out_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int W          = SAMPLE_WIDTH;
    localparam int TAB_N      = 1 << TABLE_ADDR_BITS;
    localparam int ADR_W      = TABLE_ADDR_BITS + 1;
    localparam int SIN_SUB_W  = 24 - TABLE_ADDR_BITS;
    localparam int ASIN_SUB_W = 22 - TABLE_ADDR_BITS;
    localparam int X_SHIFT    = 34 - W;
    localparam int OUT_SHIFT  = 32 - W;

    typedef logic [31:0] tab_t [TAB_N+1];

    function automatic tab_t build_sin();
        tab_t t;
        for (int i = 0; i <= TAB_N; i++) begin
            t[i] = 32'(sin_series((HALFPI_Q30 * longint'(i)) >>> TABLE_ADDR_BITS));
        end
        return t;
    endfunction

    function automatic tab_t build_asin();
        tab_t   t;
        longint y;
        longint lo;
        longint hi;
        longint mid;
        for (int i = 0; i < TAB_N; i++) begin
            y  = longint'(i) <<< (30 - TABLE_ADDR_BITS);
            lo = 0;
            hi = HALFPI_Q30;
            while (lo < hi) begin
                mid = (lo + hi + 1) >>> 1;
                if (sin_series(mid) <= y) lo = mid;
                else hi = mid - 1;
            end
            t[i] = 32'(lo);
        end
        t[TAB_N] = 32'(HALFPI_Q30);
        return t;
    endfunction

    localparam tab_t SIN_TAB  = build_sin();
    localparam tab_t ASIN_TAB = build_asin();

    typedef enum logic [4:0] {
        S_IDLE, S_HPA, S_HPA_W, S_HPB, S_HPB_W, S_SLEW, S_S9,
        S_SIN_ADR, S_RD0, S_RD1, S_RD2, S_SIN_INT, S_BEND1, S_BEND2,
        S_CLAMP, S_BQ1, S_BQ2, S_BQ3, S_CLAMP1, S_ASIN_INT, S_DONE,
        S_MUL0, S_MUL1
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   ch_reg, ch_next;

    logic signed [W-1:0]  x_reg [2];
    logic signed [W-1:0]  x_next [2];
    logic signed [39:0]   hpa_reg [2];
    logic signed [39:0]   hpa_next [2];
    logic signed [39:0]   hpb_reg [2];
    logic signed [39:0]   hpb_next [2];
    logic signed [25:0]   line_reg [2][9];
    logic signed [25:0]   line_next [2][9];
    logic signed [39:0]   hist0_reg [2];
    logic signed [39:0]   hist0_next [2];
    logic signed [39:0]   hist1_reg [2];
    logic signed [39:0]   hist1_next [2];
    logic signed [W-1:0]  res_reg [2];
    logic signed [W-1:0]  res_next [2];

    logic signed [41:0]   opa_reg, opa_next;
    logic signed [36:0]   opb_reg, opb_next;
    logic signed [78:0]   acc_reg, acc_next;
    logic signed [31:0]   v_reg, v_next;
    logic signed [25:0]   c_reg, c_next;
    logic                 pos_reg, pos_next;
    logic [1:0]           quad_reg, quad_next;
    logic                 full_reg, full_next;
    logic                 neg_reg, neg_next;
    logic                 use_asin_reg, use_asin_next;
    logic [SIN_SUB_W-1:0] sub_reg, sub_next;
    logic [ADR_W-1:0]     rom_addr_reg, rom_addr_next;
    logic [31:0]          rom_q_reg, rom_q_next;
    logic [31:0]          t0_reg, t0_next;
    logic signed [39:0]   pa29_reg, pa29_next;
    logic signed [39:0]   pa28_reg, pa28_next;
    logic signed [42:0]   pb1_reg, pb1_next;
    logic signed [39:0]   o_reg, o_next;

    logic [31:0]          iir_reg, iir_next;
    logic [1:0]           tap_reg, tap_next;
    logic                 bq_en_reg, bq_en_next;
    logic signed [31:0]   a0_reg, a0_next;
    logic signed [31:0]   b1_reg, b1_next;
    logic signed [31:0]   b2_reg, b2_next;

    logic                 m_valid_reg, m_valid_next;
    csid_out_t            m_data_reg, m_data_next;

    // shared multiplier: 42 x 19 bits per cycle, two passes per product
    logic signed [18:0]   mul_chunk;
    logic signed [60:0]   mul_prod;

    assign mul_chunk = (state_reg == S_MUL1) ? opb_reg[36:18] : $signed({1'b0, opb_reg[17:0]});
    assign mul_prod  = opa_reg * mul_chunk;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    logic signed [41:0]   x32;
    logic signed [40:0]   hpa_wide;
    logic [40:0]          hpa_abs;
    logic [40:0]          rate2;
    logic signed [47:0]   hp_diff;
    logic signed [25:0]   slew_v;
    logic signed [28:0]   s9;
    logic signed [28:0]   ang;
    logic [25:0]          p26;
    logic [24:0]          f25;
    logic signed [32:0]   sin_v;
    logic signed [26:0]   c_abs;
    logic signed [31:0]   bend_m;
    logic signed [31:0]   vc;
    logic signed [31:0]   v_abs;
    logic [22:0]          a23;
    logic signed [39:0]   o_new;
    logic signed [32:0]   r_full;
    logic signed [32:0]   r_shift;
    logic signed [32:0]   r_sgn;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        ch_next       = ch_reg;
        x_next        = x_reg;
        hpa_next      = hpa_reg;
        hpb_next      = hpb_reg;
        line_next     = line_reg;
        hist0_next    = hist0_reg;
        hist1_next    = hist1_reg;
        res_next      = res_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        acc_next      = acc_reg;
        v_next        = v_reg;
        c_next        = c_reg;
        pos_next      = pos_reg;
        quad_next     = quad_reg;
        full_next     = full_reg;
        neg_next      = neg_reg;
        use_asin_next = use_asin_reg;
        sub_next      = sub_reg;
        rom_addr_next = rom_addr_reg;
        rom_q_next    = use_asin_reg ? ASIN_TAB[rom_addr_reg] : SIN_TAB[rom_addr_reg];
        t0_next       = t0_reg;
        pa29_next     = pa29_reg;
        pa28_next     = pa28_reg;
        pb1_next      = pb1_reg;
        o_next        = o_reg;
        iir_next      = iir_reg;
        tap_next      = tap_reg;
        bq_en_next    = bq_en_reg;
        a0_next       = a0_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        x32      = 42'(x_reg[ch_reg]) <<< X_SHIFT;
        hpa_wide = 41'(hpa_reg[ch_reg]);
        hpa_abs  = hpa_wide[40] ? 41'(-hpa_wide) : 41'(hpa_wide);
        rate2    = hpa_abs + EPS_Q32;
        if (rate2 > RATE2_CAP) rate2 = RATE2_CAP;
        hp_diff  = 48'(x32) - 48'(hpb_reg[ch_reg]);
        slew_v   = sat26(hp_diff >>> 10);
        s9       = 29'(line_reg[ch_reg][0]) - (29'(line_reg[ch_reg][4]) <<< 1)
                 + 29'(line_reg[ch_reg][8]);
        ang      = (s9 > THRESH_Q22) ? (s9 - THRESH_Q22) : (-s9 - THRESH_Q22);
        p26      = acc_reg[53:28];
        f25      = p26[24] ? (25'(1 << 24) - {1'b0, p26[23:0]}) : {1'b0, p26[23:0]};
        sin_v    = $signed({1'b0, t0_reg}) + 33'(acc_reg >>> SIN_SUB_W);
        if (quad_reg[1]) sin_v = -sin_v;
        c_abs    = c_reg[25] ? -27'(c_reg) : 27'(c_reg);
        bend_m   = 32'(acc_reg >>> 30);
        vc       = v_reg;
        if (state_reg == S_CLAMP) begin
            if (v_reg > HALFPI_Q22) vc = HALFPI_Q22;
            if (v_reg < -HALFPI_Q22) vc = -HALFPI_Q22;
        end else begin
            if (v_reg > ONE_Q22) vc = ONE_Q22;
            if (v_reg < -ONE_Q22) vc = -ONE_Q22;
        end
        v_abs    = vc[31] ? -vc : vc;
        a23      = v_abs[22:0];
        o_new    = sat40(48'(acc_reg >>> 29) + 48'(hist0_reg[ch_reg]));
        r_full   = $signed({1'b0, t0_reg}) + 33'(acc_reg >>> ASIN_SUB_W);
        r_shift  = r_full >>> OUT_SHIFT;
        r_sgn    = neg_reg ? -r_shift : r_shift;

        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_IIR_AMOUNT_A:  iir_next   = cfg_wdata;
                CFG_TAP_SPACING:   tap_next   = cfg_wdata[1:0];
                CFG_BIQUAD_ENABLE: bq_en_next = cfg_wdata[0];
                CFG_COEF_A0:       a0_next    = $signed(cfg_wdata);
                CFG_COEF_B1:       b1_next    = $signed(cfg_wdata);
                CFG_COEF_B2:       b2_next    = $signed(cfg_wdata);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x_next[0]  = s_data.sample_left;
                    x_next[1]  = s_data.sample_right;
                    ch_next    = 1'b0;
                    state_next = S_HPA;
                end
            end
            S_HPA: begin
                opa_next   = x32 - 42'(hpa_reg[ch_reg]);
                opb_next   = 37'(iir_reg);
                ret_next   = S_HPA_W;
                state_next = S_MUL0;
            end
            S_HPA_W: begin
                hpa_next[ch_reg] = sat40(48'(hpa_reg[ch_reg]) + 48'(acc_reg >>> 32));
                state_next       = S_HPB;
            end
            S_HPB: begin
                opa_next   = 42'(hpa_reg[ch_reg]) - 42'(hpb_reg[ch_reg]);
                opb_next   = 37'(rate2);
                ret_next   = S_HPB_W;
                state_next = S_MUL0;
            end
            S_HPB_W: begin
                hpb_next[ch_reg] = sat40(48'(hpb_reg[ch_reg]) + 48'(acc_reg >>> 32));
                state_next       = S_SLEW;
            end
            S_SLEW: begin
                case (tap_reg)
                    TAP_D1: begin
                        line_next[ch_reg][8] = line_reg[ch_reg][4];
                        line_next[ch_reg][4] = line_reg[ch_reg][0];
                    end
                    TAP_D2: begin
                        for (int i = 2; i <= 8; i += 2) begin
                            line_next[ch_reg][i] = line_reg[ch_reg][i-2];
                        end
                    end
                    default: begin
                        for (int i = 1; i <= 8; i++) begin
                            line_next[ch_reg][i] = line_reg[ch_reg][i-1];
                        end
                    end
                endcase
                line_next[ch_reg][0] = slew_v;
                v_next               = 32'(slew_v);
                state_next           = S_S9;
            end
            S_S9: begin
                c_next   = line_reg[ch_reg][4];
                pos_next = (s9 > THRESH_Q22);
                if ((s9 > THRESH_Q22) || (-s9 > THRESH_Q22)) begin
                    opa_next   = 42'(ang);
                    opb_next   = TWO_OVER_PI_Q30;
                    ret_next   = S_SIN_ADR;
                    state_next = S_MUL0;
                end else begin
                    state_next = S_CLAMP;
                end
            end
            S_SIN_ADR: begin
                quad_next     = p26[25:24];
                sub_next      = f25[SIN_SUB_W-1:0];
                rom_addr_next = f25[24:SIN_SUB_W];
                full_next     = f25[24];
                use_asin_next = 1'b0;
                state_next    = S_RD0;
            end
            S_RD0: begin
                if (!full_reg) rom_addr_next = rom_addr_reg + 1'b1;
                state_next = S_RD1;
            end
            S_RD1: begin
                t0_next    = rom_q_reg;
                state_next = S_RD2;
            end
            S_RD2: begin
                opa_next   = 42'($signed({1'b0, rom_q_reg}) - $signed({1'b0, t0_reg}));
                opb_next   = 37'(sub_reg);
                ret_next   = use_asin_reg ? S_ASIN_INT : S_SIN_INT;
                state_next = S_MUL0;
            end
            S_SIN_INT: begin
                opa_next   = 42'(c_abs);
                opb_next   = 37'(sin_v);
                ret_next   = S_BEND1;
                state_next = S_MUL0;
            end
            S_BEND1: begin
                opa_next   = 42'(acc_reg >>> 30);
                opb_next   = BEND_Q30;
                ret_next   = S_BEND2;
                state_next = S_MUL0;
            end
            S_BEND2: begin
                v_next     = pos_reg ? (32'(c_reg) + bend_m) : (32'(c_reg) - bend_m);
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                v_next = vc;
                if (bq_en_reg) begin
                    opa_next   = 42'(vc) <<< 10;
                    opb_next   = 37'(a0_reg);
                    ret_next   = S_BQ1;
                    state_next = S_MUL0;
                end else begin
                    state_next = S_CLAMP1;
                end
            end
            S_BQ1: begin
                pa29_next  = 40'(acc_reg >>> 29);
                pa28_next  = 40'(acc_reg >>> 28);
                o_next     = o_new;
                opa_next   = 42'(o_new);
                opb_next   = 37'(b1_reg);
                ret_next   = S_BQ2;
                state_next = S_MUL0;
            end
            S_BQ2: begin
                pb1_next   = 43'(acc_reg >>> 29);
                opa_next   = 42'(o_reg);
                opb_next   = 37'(b2_reg);
                ret_next   = S_BQ3;
                state_next = S_MUL0;
            end
            S_BQ3: begin
                hist0_next[ch_reg] = sat40(48'(pa28_reg) - 48'(pb1_reg)
                                   + 48'(hist1_reg[ch_reg]));
                hist1_next[ch_reg] = sat40(48'(pa29_reg) - 48'(acc_reg >>> 29));
                v_next             = 32'(o_reg >>> 10);
                state_next         = S_CLAMP1;
            end
            S_CLAMP1: begin
                neg_next      = vc[31];
                sub_next      = SIN_SUB_W'(a23[ASIN_SUB_W-1:0]);
                rom_addr_next = a23[22:ASIN_SUB_W];
                full_next     = a23[22];
                use_asin_next = 1'b1;
                state_next    = S_RD0;
            end
            S_ASIN_INT: begin
                res_next[ch_reg] = r_sgn[W-1:0];
                if (!ch_reg) begin
                    ch_next    = 1'b1;
                    state_next = S_HPA;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_left  = res_reg[0];
                    m_data_next.out_right = res_reg[1];
                    state_next           = S_IDLE;
                end
            end
            S_MUL0: begin
                acc_next   = 79'(mul_prod);
                state_next = S_MUL1;
            end
            S_MUL1: begin
                acc_next   = acc_reg + (79'(mul_prod) <<< 18);
                state_next = ret_reg;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        res_reg      <= res_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        v_reg        <= v_next;
        c_reg        <= c_next;
        pos_reg      <= pos_next;
        quad_reg     <= quad_next;
        full_reg     <= full_next;
        neg_reg      <= neg_next;
        sub_reg      <= sub_next;
        rom_q_reg    <= rom_q_next;
        t0_reg       <= t0_next;
        pa29_reg     <= pa29_next;
        pa28_reg     <= pa28_next;
        pb1_reg      <= pb1_next;
        o_reg        <= o_next;
        m_data_reg   <= m_data_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            ch_reg       <= 1'b0;
            use_asin_reg <= 1'b0;
            rom_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                hpa_reg[c]   <= '0;
                hpb_reg[c]   <= '0;
                hist0_reg[c] <= '0;
                hist1_reg[c] <= '0;
                for (int i = 0; i < 9; i++) begin
                    line_reg[c][i] <= '0;
                end
            end
            iir_reg   <= IIR_AMOUNT_A_RST;
            tap_reg   <= TAP_D1;
            bq_en_reg <= 1'b0;
            a0_reg    <= '0;
            b1_reg    <= '0;
            b2_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            ch_reg       <= ch_next;
            use_asin_reg <= use_asin_next;
            rom_addr_reg <= rom_addr_next;
            m_valid_reg  <= m_valid_next;
            hpa_reg      <= hpa_next;
            hpb_reg      <= hpb_next;
            hist0_reg    <= hist0_next;
            hist1_reg    <= hist1_next;
            line_reg     <= line_next;
            iir_reg      <= iir_next;
            tap_reg      <= tap_next;
            bq_en_reg    <= bq_en_next;
            a0_reg       <= a0_next;
            b1_reg       <= b1_next;
            b2_reg       <= b2_next;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in progress");

    a_mul_two_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL1 |-> $past(state_reg) == S_MUL0)
        else $error("multiplier high pass without low pass");

    a_rom_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rom_addr_reg <= ADR_W'(TAB_N))
        else $error("table address out of range");

    a_done_after_right: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> ch_reg)
        else $error("word finished before right channel");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_DONE)
        else $error("output valid raised outside final step");

endmodule

`default_nettype wire

### test/console_sub_input_decode_test.sv
// Self-checking testbench for console_sub_input_decode: a bit-exact predictor
// of the stereo decode chain checks every output word. Depends on csid_pkg and the RTL.
`timescale 1ns / 1ps

module console_sub_input_decode_test;
    import csid_pkg::*;

    localparam int  TAB_BITS   = 10;
    localparam int  TAB_LEN    = 1 << TAB_BITS;
    localparam int  IDLE_LIMIT = 4000;
    localparam longint K_THRESH = longint'(((64'd73824539 << 22) + 64'd50000000) / 64'd100000000);
    localparam longint K_BEND   = longint'(((64'd26175461 << 30) + 64'd50000000) / 64'd100000000);
    localparam longint K_HPI22  = longint'(((64'd157079633 << 22) + 64'd50000000) / 64'd100000000);
    localparam longint K_HPI30  = longint'(((64'd157079633 << 30) + 64'd50000000) / 64'd100000000);
    localparam longint K_2PI30  = longint'(((64'd63661977 << 30) + 64'd50000000) / 64'd100000000);
    localparam longint K_EPS    = longint'(((64'd1 << 32) + 64'd50000) / 64'd100000);
    localparam longint K_ONE    = 64'sd1 << 22;
    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = 24'sh800000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    csid_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    csid_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_wdata = '0;

    console_sub_input_decode dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state and register copies
    longint sin_lut [0:TAB_LEN];
    longint asin_lut [0:TAB_LEN];
    longint hp_a [0:1];
    longint hp_b [0:1];
    longint slew [0:1][0:8];
    longint bq_h [0:1][0:1];
    longint rate_a;
    int     spacing;
    bit     bq_on;
    longint c_a0, c_b1, c_b2;

    csid_out_t decoded_q[$];
    int  errors = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  bends = 0;
    bit  no_idle = 1'b0;

    function automatic longint taylor_sin(longint x);
        logic [63:0] ux, x2, term;
        longint sum;
        ux   = x;
        x2   = (ux * ux) >> 30;
        term = ux;
        sum  = x;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return sum;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint lim;
        lim = 64'sd1 <<< (bits - 1);
        if (v >= lim) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint fmul(longint v, longint c, int sh);
        longint ch, cl;
        ch = c >>> 16;
        cl = c & 64'hFFFF;
        return (v * ch + ((v * cl) >>> 16)) >>> (sh - 16);
    endfunction

    function automatic longint lut_sin(longint ang);
        logic [63:0] p;
        longint f, idx, sub, v;
        logic [1:0] quad;
        p    = (64'(ang) * 64'(K_2PI30)) >> 28;
        quad = p[25:24];
        f    = longint'(p[23:0]);
        if (quad[0]) f = (64'sd1 << 24) - f;
        idx = f >>> (24 - TAB_BITS);
        sub = f & ((64'sd1 << (24 - TAB_BITS)) - 1);
        if (idx >= TAB_LEN) v = sin_lut[TAB_LEN];
        else v = sin_lut[idx] + (((sin_lut[idx+1] - sin_lut[idx]) * sub) >>> (24 - TAB_BITS));
        return quad[1] ? -v : v;
    endfunction

    function automatic longint lut_asin(longint a);
        longint idx, sub;
        idx = a >>> (22 - TAB_BITS);
        sub = a & ((64'sd1 << (22 - TAB_BITS)) - 1);
        if (idx >= TAB_LEN) return asin_lut[TAB_LEN];
        return asin_lut[idx] + (((asin_lut[idx+1] - asin_lut[idx]) * sub) >>> (22 - TAB_BITS));
    endfunction

    function automatic logic [23:0] decode_channel(int ch, logic signed [23:0] raw);
        longint x32, rate2, v, s9, c, mag, ang, m, xin, o, r;
        int step;
        x32 = longint'(raw) * 1024;
        hp_a[ch] = clip(hp_a[ch] + fmul(x32 - hp_a[ch], rate_a, 32), 40);
        rate2 = (hp_a[ch] < 0 ? -hp_a[ch] : hp_a[ch]) + K_EPS;
        if (rate2 > (64'sd1 << 35)) rate2 = 64'sd1 << 35;
        hp_b[ch] = clip(hp_b[ch] + fmul(hp_a[ch] - hp_b[ch], rate2, 32), 40);
        v = clip((x32 - hp_b[ch]) >>> 10, 26);
        step = spacing == TAP_D1 ? 4 : (spacing == TAP_D2 ? 2 : 1);
        for (int i = 8; i >= step; i -= step) slew[ch][i] = slew[ch][i-step];
        slew[ch][0] = v;
        s9 = slew[ch][0] - 2 * slew[ch][4] + slew[ch][8];
        if (s9 > K_THRESH || -s9 > K_THRESH) begin
            bends++;
            c   = slew[ch][4];
            mag = c < 0 ? -c : c;
            ang = s9 > K_THRESH ? s9 - K_THRESH : -s9 - K_THRESH;
            m   = (((mag * lut_sin(ang)) >>> 30) * K_BEND) >>> 30;
            v   = s9 > K_THRESH ? c + m : c - m;
        end
        if (v > K_HPI22) v = K_HPI22;
        if (v < -K_HPI22) v = -K_HPI22;
        if (bq_on) begin
            xin = v * 1024;
            o = clip(fmul(xin, c_a0, 29) + bq_h[ch][0], 40);
            bq_h[ch][0] = clip(fmul(xin, c_a0, 28) - fmul(o, c_b1, 29) + bq_h[ch][1], 40);
            bq_h[ch][1] = clip(fmul(xin, c_a0, 29) - fmul(o, c_b2, 29), 40);
            v = o >>> 10;
        end
        if (v > K_ONE) v = K_ONE;
        if (v < -K_ONE) v = -K_ONE;
        r = lut_asin(v < 0 ? -v : v) >>> 8;
        if (v < 0) r = -r;
        return r[23:0];
    endfunction

    function automatic csid_out_t decode_pair(csid_in_t w);
        csid_out_t res;
        res.out_left  = decode_channel(0, w.sample_left);
        res.out_right = decode_channel(1, w.sample_right);
        return res;
    endfunction

    task automatic build_luts();
        longint y, lo, hi, mid;
        for (int i = 0; i <= TAB_LEN; i++) sin_lut[i] = taylor_sin((K_HPI30 * i) >>> TAB_BITS);
        for (int i = 0; i < TAB_LEN; i++) begin
            y  = longint'(i) << (30 - TAB_BITS);
            lo = 0;
            hi = K_HPI30;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (taylor_sin(mid) <= y) lo = mid;
                else hi = mid - 1;
            end
            asin_lut[i] = lo;
        end
        asin_lut[TAB_LEN] = K_HPI30;
        for (int ch = 0; ch < 2; ch++) begin
            hp_a[ch] = 0;
            hp_b[ch] = 0;
            bq_h[ch][0] = 0;
            bq_h[ch][1] = 0;
            for (int i = 0; i < 9; i++) slew[ch][i] = 0;
        end
        rate_a  = longint'(IIR_AMOUNT_A_RST);
        spacing = 0;
        bq_on   = 1'b0;
        c_a0 = 0;
        c_b1 = 0;
        c_b2 = 0;
    endtask

    task automatic drain();
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IIR_AMOUNT_A:  rate_a  = longint'(data);
            CFG_TAP_SPACING:   spacing = int'(data[1:0]);
            CFG_BIQUAD_ENABLE: bq_on   = data[0];
            CFG_COEF_A0:       c_a0    = longint'($signed(data));
            CFG_COEF_B1:       c_b1    = longint'($signed(data));
            CFG_COEF_B2:       c_b2    = longint'($signed(data));
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pair(logic signed [23:0] left, logic signed [23:0] right);
        if (!no_idle) repeat ($urandom_range(0, 3)) @(negedge aclk);
        s_valid = 1'b1;
        s_data.sample_left  = left;
        s_data.sample_right = right;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decoded_q.push_back(decode_pair(s_data));
        words_in++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic signed [23:0] rand_sample();
        return 24'($urandom);
    endfunction

    // receiver stalls
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b0;
            if (!no_idle) repeat ($urandom_range(0, 3)) @(negedge aclk);
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        csid_out_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (decoded_q.size() == 0) begin
                $error("output word with nothing expected: %h", m_data);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                if (m_data.out_left !== want.out_left) begin
                    $error("out_left expected %0d got %0d", want.out_left, m_data.out_left);
                    errors++;
                end
                if (m_data.out_right !== want.out_right) begin
                    $error("out_right expected %0d got %0d", want.out_right, m_data.out_right);
                    errors++;
                end
            end
        end
    end

    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= IDLE_LIMIT) begin
            $display("console_sub_input_decode_test: errors");
            $finish;
        end
    end

    task automatic test_extremes();
        send_pair(24'sd0, 24'sd0);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(24'sd4194304, -24'sd4194304);
        send_pair(-24'sd4194304, 24'sd4194304);
        send_pair(24'sd1, -24'sd1);
    endtask

    task automatic test_bend();
        for (int i = 0; i < 6; i++) send_pair(i % 2 ? S_MIN : S_MAX, i % 2 ? S_MAX : S_MIN);
    endtask

    task automatic test_spacing();
        for (int code = 1; code <= 3; code++) begin
            write_reg(CFG_TAP_SPACING, 32'(code));
            send_pair(S_MAX, S_MIN);
            send_pair(S_MIN, S_MAX);
        end
        write_reg(CFG_TAP_SPACING, 32'(TAP_D1));
    endtask

    task automatic test_biquad();
        write_reg(CFG_COEF_A0, 32'd5368709);
        write_reg(CFG_COEF_B1, 32'hC6666666);
        write_reg(CFG_COEF_B2, 32'd440234147);
        write_reg(CFG_BIQUAD_ENABLE, 32'd1);
        send_pair(S_MAX, S_MIN);
        send_pair(24'sd2000000, -24'sd2000000);
        write_reg(CFG_COEF_A0, 32'h7FFFFFFF);
        write_reg(CFG_COEF_B1, 32'h80000000);
        write_reg(CFG_COEF_B2, 32'h7FFFFFFF);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, 24'sd0);
        write_reg(CFG_BIQUAD_ENABLE, 32'd0);
    endtask

    task automatic test_rate();
        write_reg(CFG_IIR_AMOUNT_A, 32'd0);
        send_pair(S_MAX, S_MIN);
        send_pair(24'sd123456, -24'sd654321);
        write_reg(CFG_IIR_AMOUNT_A, 32'hFFFFFFFF);
        send_pair(S_MIN, S_MAX);
        send_pair(24'sd0, 24'sd7);
    endtask

    task automatic test_random();
        logic signed [23:0] walk_l, walk_r;
        int amp;
        for (int ph = 0; ph < 11; ph++) begin
            case ($urandom_range(0, 4))
                0: write_reg(CFG_IIR_AMOUNT_A, IIR_AMOUNT_A_RST);
                1: write_reg(CFG_IIR_AMOUNT_A, 32'd0);
                2: write_reg(CFG_IIR_AMOUNT_A, 32'hFFFFFFFF);
                3: write_reg(CFG_IIR_AMOUNT_A, $urandom_range(0, 1 << 24));
                default: write_reg(CFG_IIR_AMOUNT_A, $urandom);
            endcase
            write_reg(CFG_TAP_SPACING, $urandom_range(0, 3));
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_COEF_A0, $urandom_range(1000000, 40000000));
                write_reg(CFG_COEF_B1, -$urandom_range(600000000, 1000000000));
                write_reg(CFG_COEF_B2, $urandom_range(100000000, 480000000));
            end else begin
                write_reg(CFG_COEF_A0, $urandom);
                write_reg(CFG_COEF_B1, $urandom);
                write_reg(CFG_COEF_B2, $urandom);
            end
            write_reg(CFG_BIQUAD_ENABLE, $urandom_range(0, 1));
            no_idle = (ph == 3);
            walk_l = 0;
            walk_r = 0;
            amp = $urandom_range(1000, 8000000);
            for (int n = 0; n < 50; n++) begin
                if (ph == 5 && n == 25) drain();
                case ($urandom_range(0, 3))
                    0: send_pair(rand_sample(), rand_sample());
                    1: begin
                        walk_l = walk_l + 24'($signed($urandom_range(0, 200000)) - 100000);
                        walk_r = walk_r + 24'($signed($urandom_range(0, 200000)) - 100000);
                        send_pair(walk_l, walk_r);
                    end
                    default: send_pair(n % 2 ? 24'(amp) : -24'(amp),
                                       n % 2 ? -24'($urandom_range(0, amp)) : 24'(amp));
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        build_luts();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_extremes();
        test_bend();
        test_spacing();
        test_biquad();
        test_rate();
        test_random();
        drain();
        repeat (200) @(negedge aclk);
        $display("covered %0d sample pairs, %0d words checked, %0d slew bends, all registers",
                 words_in, words_out, bends);
        $display("over several spacing, rate and biquad settings with random stalls");
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("console_sub_input_decode_test: clean");
        end else begin
            $display("console_sub_input_decode_test: errors");
        end
        $finish;
    end

endmodule
